// ===== rtl/core/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg
// Types and constants shared by the RGB to HMMD conversion modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

	localparam int CH_W    = 8;
	localparam int NUM_W   = 17;             // numerator below 360 * 255
	localparam int QUOT_W  = 9;              // hue below 512
	localparam int SUM_W   = NUM_W + 2;      // signed working width of the numerator
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic signed [SUM_W-1:0] HUE_STEP   = SUM_W'(60);
	localparam logic signed [SUM_W-1:0] HUE_FULL   = SUM_W'(360);
	localparam logic signed [SUM_W-1:0] GREEN_MULT = SUM_W'(2);
	localparam logic signed [SUM_W-1:0] BLUE_MULT  = SUM_W'(4);
	localparam logic [QUOT_W-1:0]       HUE_MAX    = QUOT_W'(359);

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} rhc_sector_t;

	// one request handed from the front part to the divider
	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [CH_W-1:0]  spread;
		logic [CH_W-1:0]  max_ch;
		logic [CH_W-1:0]  min_ch;
	} rhc_job_t;

	// one slot of the divider pipeline
	typedef struct packed {
		logic [NUM_W-1:0]  rem;
		logic [QUOT_W-1:0] quot;
		logic [CH_W-1:0]   spread;
		logic [CH_W-1:0]   max_ch;
		logic [CH_W-1:0]   min_ch;
	} rhc_div_t;

endpackage

`default_nettype wire

// ===== rtl/core/rhc_front.sv =====
// ----------------------------------------------------------------------------
// rhc_front
// Accept a pixel, find max, min and sector, and build the hue numerator.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_front (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire [rhc_pkg::CH_W-1:0] red,
	input  wire [rhc_pkg::CH_W-1:0] green,
	input  wire [rhc_pkg::CH_W-1:0] blue,
	output logic                    busy,
	input  wire                     q_full,
	output logic                    push,
	output rhc_pkg::rhc_job_t       job
);
	import rhc_pkg::*;

	logic              v_s1, v_s2, stall, take;
	logic [CH_W-1:0]   red_s1, green_s1, blue_s1;
	logic [CH_W-1:0]   hi, lo;
	rhc_sector_t       sec;
	logic signed [CH_W:0] diff;
	logic [CH_W-1:0]   hi_s2, lo_s2, d_s2;
	rhc_sector_t       sec_s2;
	logic signed [CH_W:0] diff_s2;
	logic signed [SUM_W-1:0] dext, sprd, prod, base, sum;

	// hold both stages while stage two holds a job and the queue is full
	assign stall = v_s2 && q_full;
	assign busy  = stall;
	assign take  = start && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= take;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
		end
		if (!stall) begin
			hi_s2   <= hi;
			lo_s2   <= lo;
			d_s2    <= hi - lo;
			sec_s2  <= sec;
			diff_s2 <= diff;
		end
	end

	always_comb begin
		hi = (red_s1 > green_s1) ? red_s1 : green_s1;
		if (blue_s1 > hi) begin
			hi = blue_s1;
		end
		lo = (red_s1 < green_s1) ? red_s1 : green_s1;
		if (blue_s1 < lo) begin
			lo = blue_s1;
		end
		// ties go to red first, then green
		if (red_s1 == hi) begin
			sec = SEC_RED;
		end else if (green_s1 == hi) begin
			sec = SEC_GREEN;
		end else begin
			sec = SEC_BLUE;
		end
		case (sec)
			SEC_RED:   diff = $signed({1'b0, green_s1}) - $signed({1'b0, blue_s1});
			SEC_GREEN: diff = $signed({1'b0, blue_s1}) - $signed({1'b0, red_s1});
			SEC_BLUE:  diff = $signed({1'b0, red_s1}) - $signed({1'b0, green_s1});
			default:   diff = '0;
		endcase
	end

	// numerator is never negative; a grey pixel gives zero
	always_comb begin
		dext = {{(SUM_W-CH_W-1){diff_s2[CH_W]}}, diff_s2};
		sprd = {{(SUM_W-CH_W){1'b0}}, d_s2};
		prod = dext * HUE_STEP;
		case (sec_s2)
			SEC_RED:   base = diff_s2[CH_W] ? sprd * HUE_FULL : '0;
			SEC_GREEN: base = sprd * (HUE_STEP * GREEN_MULT);
			SEC_BLUE:  base = sprd * (HUE_STEP * BLUE_MULT);
			default:   base = '0;
		endcase
		sum        = base + prod;
		job.num    = sum[NUM_W-1:0];
		job.spread = d_s2;
		job.max_ch = hi_s2;
		job.min_ch = lo_s2;
	end

	assign push = v_s2 && !q_full;

endmodule

`default_nettype wire

// ===== rtl/core/rhc_queue.sv =====
// ----------------------------------------------------------------------------
// rhc_queue
// Short FIFO between the front part and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  rhc_pkg::rhc_job_t wr_job,
	output logic              full,
	input  wire               pop,
	output logic              empty,
	output rhc_pkg::rhc_job_t rd_job
);
	import rhc_pkg::*;

	rhc_job_t              slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]    wptr_q, rptr_q;
	logic [Q_CNT_W-1:0]    cnt_q;
	logic                  do_push, do_pop;

	assign full    = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_job  = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= wr_job;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count above depth");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |=> cnt_q == Q_CNT_W'(Q_DEPTH))
		else $error("queue lost an entry while full");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> wptr_q == rptr_q)
		else $error("queue pointers apart while empty");

endmodule

`default_nettype wire

// ===== rtl/core/rhc_div.sv =====
// ----------------------------------------------------------------------------
// rhc_div
// Pipelined restoring divider, one quotient bit per stage, and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	input  rhc_pkg::rhc_job_t         in_job,
	output logic                      done,
	output logic [rhc_pkg::QUOT_W-1:0] hue_degrees,
	output logic [rhc_pkg::CH_W-1:0]   max_channel,
	output logic [rhc_pkg::CH_W-1:0]   min_channel,
	output logic [rhc_pkg::CH_W-1:0]   channel_spread
);
	import rhc_pkg::*;

	rhc_div_t         st_s   [QUOT_W];
	logic [QUOT_W-1:0] vld_s;
	rhc_div_t         nxt    [QUOT_W];
	logic [NUM_W-1:0] dsh    [QUOT_W];

	// stage k settles quotient bit QUOT_W-1-k
	always_comb begin
		for (int k = 0; k < QUOT_W; k++) begin
			dsh[k] = NUM_W'({{(NUM_W-CH_W){1'b0}}, st_s[k].spread} << (QUOT_W - 1 - k));
			nxt[k] = st_s[k];
			if (st_s[k].rem >= dsh[k]) begin
				nxt[k].rem                    = st_s[k].rem - dsh[k];
				nxt[k].quot[QUOT_W - 1 - k]   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			done  <= 1'b0;
		end else begin
			vld_s <= {vld_s[QUOT_W-2:0], in_valid};
			done  <= vld_s[QUOT_W-1];
		end
	end

	always_ff @(posedge clk) begin
		st_s[0].rem    <= in_job.num;
		st_s[0].quot   <= '0;
		st_s[0].spread <= in_job.spread;
		st_s[0].max_ch <= in_job.max_ch;
		st_s[0].min_ch <= in_job.min_ch;
		for (int k = 1; k < QUOT_W; k++) begin
			st_s[k] <= nxt[k-1];
		end
		// grey pixel: the quotient is meaningless, force zero
		hue_degrees    <= (nxt[QUOT_W-1].spread == '0) ? '0 : nxt[QUOT_W-1].quot;
		max_channel    <= nxt[QUOT_W-1].max_ch;
		min_channel    <= nxt[QUOT_W-1].min_ch;
		channel_spread <= nxt[QUOT_W-1].spread;
	end

endmodule

`default_nettype wire

// ===== rtl/core/rgb_to_hmmd_convert.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hmmd_convert
// RGB pixel to HMMD colour components (hue, max, min, spread).
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive red, green and blue with start high; the request
//   is taken at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with hue_degrees,
//   max_channel, min_channel and channel_spread valid in that cycle. The
//   receiver has no way to hold results off and must take every one.
//   Path: the first front stage loads on the accepting edge, then the second
//   front stage, the queue write, 9 divider stages and the result register.
//   Throughput: one pixel per clock; the divider settles one quotient bit per
//   stage, so each stage is one 17-bit compare and subtract.
//   busy rises only if the queue between the front part and the divider
//   fills; the divider drains the queue on every cycle it holds a request,
//   so it never holds more than one and busy stays low.
//   Reset: arst_n clears all valid bits and queue pointers at once; no
//   results are pending after reset and the block accepts on the next edge.
//   Grey pixels (spread zero) give hue 0; ties on the maximum go to red,
//   then green.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hmmd_convert (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	output logic                        busy,
	input  wire [rhc_pkg::CH_W-1:0]     red,
	input  wire [rhc_pkg::CH_W-1:0]     green,
	input  wire [rhc_pkg::CH_W-1:0]     blue,
	output logic                        done,
	output logic [rhc_pkg::QUOT_W-1:0]  hue_degrees,
	output logic [rhc_pkg::CH_W-1:0]    max_channel,
	output logic [rhc_pkg::CH_W-1:0]    min_channel,
	output logic [rhc_pkg::CH_W-1:0]    channel_spread
);
	import rhc_pkg::*;

	rhc_job_t front_job, head_job;
	logic     push, q_full, q_empty;

	// front part: take the pixel, classify its sector, build the numerator
	rhc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.busy   (busy),
		.q_full (q_full),
		.push   (push),
		.job    (front_job)
	);

	// queue: decouple the front part from the divider
	rhc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (front_job),
		.full   (q_full),
		.pop    (!q_empty),
		.empty  (q_empty),
		.rd_job (head_job)
	);

	// back part: drain one request per cycle into the divider pipeline
	rhc_div u_div (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (!q_empty),
		.in_job         (head_job),
		.done           (done),
		.hue_degrees    (hue_degrees),
		.max_channel    (max_channel),
		.min_channel    (min_channel),
		.channel_spread (channel_spread)
	);

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> hue_degrees <= HUE_MAX)
		else $error("hue out of range");
	a_spread: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> channel_spread == max_channel - min_channel)
		else $error("spread does not match max minus min");
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		done && max_channel == min_channel |-> hue_degrees == '0)
		else $error("grey pixel with non-zero hue");
	a_no_busy_idle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> q_full)
		else $error("busy raised with room in the queue");

endmodule

`default_nettype wire

// ===== tb/hmmd_result_checker.sv =====
// ----------------------------------------------------------------------------
// hmmd_result_checker
// Watches the pixel request and result channels of the RGB to HMMD converter,
// predicts each result from the accepted request and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hmmd_result_checker (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire                         busy,
	input  wire [rhc_pkg::CH_W-1:0]     red,
	input  wire [rhc_pkg::CH_W-1:0]     green,
	input  wire [rhc_pkg::CH_W-1:0]     blue,
	input  wire                         done,
	input  wire [rhc_pkg::QUOT_W-1:0]   hue_degrees,
	input  wire [rhc_pkg::CH_W-1:0]     max_channel,
	input  wire [rhc_pkg::CH_W-1:0]     min_channel,
	input  wire [rhc_pkg::CH_W-1:0]     channel_spread,
	output int                          mismatch_count,
	output int                          pixels_in_flight
);
	import rhc_pkg::*;

	typedef struct packed {
		logic [QUOT_W-1:0] hue;
		logic [CH_W-1:0]   max_ch;
		logic [CH_W-1:0]   min_ch;
		logic [CH_W-1:0]   spread;
	} hmmd_px_t;

	hmmd_px_t hmmd_expected[$];
	hmmd_px_t want;

	initial mismatch_count = 0;

	// exact integer form of the six-sector hue; ties go to red, then green
	function automatic hmmd_px_t predict_hmmd(input logic [CH_W-1:0] r, g, b);
		int          hi, lo, d, num, hue;
		rhc_sector_t sector;
		hmmd_px_t    px;
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		d   = hi - lo;
		hue = 0;
		if (d != 0) begin
			if (r == hi) sector = SEC_RED;
			else if (g == hi) sector = SEC_GREEN;
			else sector = SEC_BLUE;
			case (sector)
				SEC_RED: begin
					num = 60 * (int'(g) - int'(b));
					if (num < 0) num += 360 * d;
				end
				SEC_GREEN: num = 120 * d + 60 * (int'(b) - int'(r));
				default:   num = 240 * d + 60 * (int'(r) - int'(g));
			endcase
			if (num < 0) num = 0;
			hue = num / d;
			if (hue > 359) hue = 359;
		end
		px.hue    = QUOT_W'(hue);
		px.max_ch = CH_W'(hi);
		px.min_ch = CH_W'(lo);
		px.spread = CH_W'(d);
		return px;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hmmd_expected.delete();
			pixels_in_flight <= 0;
		end else begin
			// retire first, so a result with nothing waiting is never matched to
			// a request taken on the same edge
			if (done) begin
				if (hmmd_expected.size() == 0) begin
					$error("result with no request waiting: hue %0d max %0d min %0d spread %0d",
						hue_degrees, max_channel, min_channel, channel_spread);
					mismatch_count++;
				end else begin
					want = hmmd_expected.pop_front();
					if (hue_degrees !== want.hue) begin
						$error("hue_degrees: expected %0d, actual %0d", want.hue, hue_degrees);
						mismatch_count++;
					end
					if (max_channel !== want.max_ch) begin
						$error("max_channel: expected %0d, actual %0d", want.max_ch, max_channel);
						mismatch_count++;
					end
					if (min_channel !== want.min_ch) begin
						$error("min_channel: expected %0d, actual %0d", want.min_ch, min_channel);
						mismatch_count++;
					end
					if (channel_spread !== want.spread) begin
						$error("channel_spread: expected %0d, actual %0d",
							want.spread, channel_spread);
						mismatch_count++;
					end
				end
			end
			if (start && !busy)
				hmmd_expected.push_back(predict_hmmd(red, green, blue));
			pixels_in_flight <= hmmd_expected.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives pixel requests into the RGB to HMMD converter in random bursts and
// gaps, after a directed set of corner pixels, and gives the verdict from the
// checker's mismatch count and its count of pixels still in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

	import rhc_pkg::*;

	localparam int RANDOM_PIXELS = 1950;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 20;

	// corner pixels, {red, green, blue}
	localparam logic [23:0] CORNER_PIXELS [22] = '{
		24'h000000,  // grey, black
		24'hFFFFFF,  // grey, white
		24'h808080,  // grey, mid level
		24'hFF0000,  // pure red, hue 0
		24'hFF8080,  // red largest with green equal to blue
		24'hFF00FF,  // red and blue tie on the maximum: red sector wraps
		24'hFFFF00,  // red and green tie: red sector
		24'h00FF00,  // pure green
		24'h00FFFF,  // green and blue tie: green sector
		24'h0000FF,  // pure blue
		24'hFF0001,  // hue just under 360
		24'hFF0100,  // red sector, quotient rounds down to 0
		24'h01FF00,  // green sector just under 120
		24'h00FEFF,  // blue sector, large negative offset
		24'hFF00FE,  // red wrap with large offset
		24'h010000,  // spread of one
		24'h010002,  // blue sector, spread two
		24'h020100,  // red sector, spread two
		24'h7F8081,  // blue sector, small spread mid range
		24'hFF0080,
		24'h80FF00,
		24'h55AAFF
	};

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	logic [CH_W-1:0]   red    = '0;
	logic [CH_W-1:0]   green  = '0;
	logic [CH_W-1:0]   blue   = '0;
	wire               busy;
	wire               done;
	wire [QUOT_W-1:0]  hue_degrees;
	wire [CH_W-1:0]    max_channel;
	wire [CH_W-1:0]    min_channel;
	wire [CH_W-1:0]    channel_spread;
	int                mismatch_count;
	int                pixels_in_flight;
	int                cycle_count = 0;
	int                pixels_sent;
	int                burst_len;
	int                gap_len;
	logic [23:0]       px;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rgb_to_hmmd_convert DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.done           (done),
		.hue_degrees    (hue_degrees),
		.max_channel    (max_channel),
		.min_channel    (min_channel),
		.channel_spread (channel_spread)
	);

	hmmd_result_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.red              (red),
		.green            (green),
		.blue             (blue),
		.done             (done),
		.hue_degrees      (hue_degrees),
		.max_channel      (max_channel),
		.min_channel      (min_channel),
		.channel_spread   (channel_spread),
		.mismatch_count   (mismatch_count),
		.pixels_in_flight (pixels_in_flight)
	);

	// watchdog: abandon the run if the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// present one request and hold it until an edge takes it; start stays high
	// on return so back-to-back requests need no second assignment
	task automatic send_pixel(input logic [23:0] rgb);
		start <= 1'b1;
		red   <= rgb[23:16];
		green <= rgb[15:8];
		blue  <= rgb[7:0];
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// drop start and wait until every request has come back
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pixels_in_flight != 0);
	endtask

	function automatic logic [7:0] edge_level();
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'h01;
			2:       return 8'hFE;
			default: return 8'hFF;
		endcase
	endfunction

	// mostly uniform pixels, weighted towards greys, ties and extreme levels
	function automatic logic [23:0] random_pixel();
		logic [7:0] a, b;
		a = 8'($urandom);
		b = 8'($urandom);
		case ($urandom_range(0, 9))
			0: return {a, a, a};
			1: begin
				if (a < b) a = b;
				case ($urandom_range(0, 2))
					0:       return {a, a, b};
					1:       return {a, b, a};
					default: return {b, a, a};
				endcase
			end
			2:       return {edge_level(), edge_level(), edge_level()};
			3:       return {a, b, edge_level()};
			default: return 24'($urandom);
		endcase
	endfunction

	initial begin
		// hold reset, then release it on an edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (CORNER_PIXELS[i])
			send_pixel(CORNER_PIXELS[i]);

		// let the pipeline empty completely before the random traffic
		drain_results();

		pixels_sent = 0;
		while (pixels_sent < RANDOM_PIXELS) begin
			burst_len = $urandom_range(1, 40);
			for (int i = 0; i < burst_len && pixels_sent < RANDOM_PIXELS; i++) begin
				px = random_pixel();
				send_pixel(px);
				pixels_sent++;
			end
			// mostly short gaps, now and then a long one
			if ($urandom_range(0, 7) == 0)
				gap_len = $urandom_range(10, 30);
			else
				gap_len = $urandom_range(0, 4);
			if (gap_len > 0)
				hold_off(gap_len);
		end

		drain_results();
		// give a stray extra result the chance to show
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pixels_in_flight == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
